/* src/ci1d_pkg.sv */
package ci1d_pkg;

	localparam int MaxSamples = 1024;
	localparam int AddrBits = $clog2(MaxSamples);
	localparam int SampleBits = 24;
	localparam int FracBits = 16;
	localparam int CountBits = 11;
	localparam int EntryBits = SampleBits + 1;

	localparam logic [1:0] CfgSampleCount = 2'd0;
	localparam logic [1:0] CfgInvStep = 2'd1;
	localparam logic [1:0] CfgGridOffset = 2'd2;

	localparam logic ReqLoad = 1'b0;
	localparam logic ReqEval = 1'b1;

	localparam logic [1:0] ModeCubic = 2'd0;
	localparam logic [1:0] ModeLinear = 2'd1;
	localparam logic [1:0] ModeNearest = 2'd2;

	typedef struct packed {
		logic req_type;
		logic [AddrBits-1:0] sample_index;
		logic signed [SampleBits-1:0] sample_value;
		logic sample_valid;
		logic signed [31:0] position;
	} req_t;

	typedef struct packed {
		logic signed [SampleBits-1:0] value;
		logic value_valid;
		logic [1:0] mode;
	} rsp_t;

endpackage

/* src/ci1d_req_if.sv */
interface ci1d_req_if;
	import ci1d_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* src/ci1d_rsp_if.sv */
interface ci1d_rsp_if;
	import ci1d_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* src/cubic_interpolator_1d_core.sv */
// channel   dir  payload                                                    transfer
// req       in   req_type, sample_index, sample_value, sample_valid, position  valid & ready
// rsp       out  value, value_valid, mode                                     valid & ready
// cfg       in   cfg_we, cfg_index, cfg_data                                  cfg_we
// one item per cycle sustained while the skid buffer is empty; an evaluate's result passes
// through 3 stages of position multiply, u clamp, tap addresses,
// ram read, coefficients, two horner stages, then the output register
// the table is two copies of one 1024-entry ram, each read at two addresses per cycle
// a load writes both copies in s5, before any younger evaluate reads there
// reset clears control and configuration registers only; the table is undefined until loaded
// a full skid buffer at the output drops req.ready; the pipeline holds while stalled
module cubic_interpolator_1d_core (
	input logic clk,
	input logic arst_n,
	ci1d_req_if.sink req,
	ci1d_rsp_if.source rsp,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import ci1d_pkg::*;

	localparam int Stages = 10;
	localparam int SB = SampleBits;
	localparam int HB = SB + 6;

	logic [CountBits-1:0] sample_count_q;
	logic [31:0] inv_step_q;
	logic signed [31:0] grid_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= CountBits'(1);
			inv_step_q <= 32'd65536;
			grid_offset_q <= 32'sd196608;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgSampleCount: sample_count_q <= cfg_data[CountBits-1:0];
				CfgInvStep: inv_step_q <= cfg_data;
				CfgGridOffset: grid_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic adv;
	logic [Stages-2:0] v_q;
	logic skid_full_q;
	rsp_t skid_q;
	logic out_valid_q;
	rsp_t out_q;
	logic req_xfer;
	assign adv = !skid_full_q;
	assign req.ready = adv;
	assign req_xfer = req.valid && req.ready;

	// s1..s3: split inverse step, low/high product partials, sum
	logic signed [31:0] pos_s1;
	logic [15:0] inv_lo_s1, inv_hi_s1;
	logic signed [48:0] plo_s2, phi_s2;
	logic signed [64:0] prod_s3;
	logic [CountBits-1:0] n_s1, n_s2, n_s3, n_s4;
	logic signed [31:0] off_s1, off_s2, off_s3;
	logic [CountBits-1:0] nclamp;
	assign nclamp = (sample_count_q == '0) ? CountBits'(1) :
		(sample_count_q > CountBits'(MaxSamples)) ? CountBits'(MaxSamples) : sample_count_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1 <= req.payload.position;
			inv_lo_s1 <= inv_step_q[15:0];
			inv_hi_s1 <= inv_step_q[31:16];
			n_s1 <= nclamp;
			off_s1 <= grid_offset_q;
			plo_s2 <= pos_s1 * $signed({1'b0, inv_lo_s1});
			phi_s2 <= pos_s1 * $signed({1'b0, inv_hi_s1});
			n_s2 <= n_s1; off_s2 <= off_s1;
			prod_s3 <= 65'(plo_s2) + (65'(phi_s2) <<< 16);
			n_s3 <= n_s2; off_s3 <= off_s2;
		end
	end

	// s4: u and clamp, s5: segment split and tap addresses
	logic signed [50:0] u_full;
	logic signed [50:0] u_top;
	logic [CountBits+FracBits-1:0] u_s4;
	assign u_full = 51'(prod_s3 >>> FracBits) + 51'(off_s3);
	assign u_top = 51'({n_s3 + CountBits'(6), {FracBits{1'b0}}});
	always_ff @(posedge clk) begin
		if (adv) begin
			if (u_full < 0) u_s4 <= '0;
			else if (u_full > u_top) u_s4 <= (CountBits+FracBits)'(u_top);
			else u_s4 <= (CountBits+FracBits)'(u_full);
			n_s4 <= n_s3;
		end
	end

	logic [CountBits-1:0] seg;
	logic [FracBits-1:0] t_s5, t_s6, t_s7, t_s8, t_s9;
	logic [AddrBits-1:0] addr_s5 [4];
	assign seg = (u_s4[CountBits+FracBits-1:FracBits] > n_s4 + CountBits'(5)) ?
		n_s4 + CountBits'(5) : u_s4[CountBits+FracBits-1:FracBits];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++) begin
				logic signed [CountBits+1:0] k;
				k = $signed({2'b0, seg}) + (CountBits+2)'(j - 4);
				if (k < 0) addr_s5[j] <= '0;
				else if (k > $signed({2'b0, n_s4}) - 1)
					addr_s5[j] <= AddrBits'(n_s4 - CountBits'(1));
				else addr_s5[j] <= AddrBits'(k);
			end
			t_s5 <= u_s4[FracBits-1:0];
		end
	end

	// load path: write in stage 5 alongside the read so order is kept
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;
	logic [AddrBits-1:0] ldi_s1, ldi_s2, ldi_s3, ldi_s4, ldi_s5;
	logic [EntryBits-1:0] ldd_s1, ldd_s2, ldd_s3, ldd_s4, ldd_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			{ld_s1, ld_s2, ld_s3, ld_s4, ld_s5} <= '0;
		end else if (adv) begin
			v_q <= {v_q[Stages-3:0], req_xfer && req.payload.req_type == ReqEval};
			ld_s1 <= req_xfer && req.payload.req_type == ReqLoad;
			ld_s2 <= ld_s1; ld_s3 <= ld_s2; ld_s4 <= ld_s3; ld_s5 <= ld_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ldi_s1 <= req.payload.sample_index;
			ldd_s1 <= {req.payload.sample_valid, req.payload.sample_value};
			ldi_s2 <= ldi_s1; ldd_s2 <= ldd_s1;
			ldi_s3 <= ldi_s2; ldd_s3 <= ldd_s2;
			ldi_s4 <= ldi_s3; ldd_s4 <= ldd_s3;
			ldi_s5 <= ldi_s4; ldd_s5 <= ldd_s4;
		end
	end

	// two ram copies, each read at two taps, read data registered in s6
	// an older load in s5 writes before a younger evaluate reads in s5
	logic [EntryBits-1:0] mem_a [MaxSamples];
	logic [EntryBits-1:0] mem_b [MaxSamples];
	logic [EntryBits-1:0] rd_s6 [4];
	logic mem_we;
	assign mem_we = adv && ld_s5;
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_a[ldi_s5] <= ldd_s5;
			mem_b[ldi_s5] <= ldd_s5;
		end
		if (adv) begin
			rd_s6[0] <= mem_a[addr_s5[0]];
			rd_s6[1] <= mem_a[addr_s5[1]];
			rd_s6[2] <= mem_b[addr_s5[2]];
			rd_s6[3] <= mem_b[addr_s5[3]];
			t_s6 <= t_s5;
		end
	end

	logic [EntryBits-1:0] z6 [4];
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			z6[j] = rd_s6[j];
		end
	end

	// s7: coefficients and mode
	logic signed [SB+3:0] ca_s7, cb_s7, cc_s7, cd_s7;
	logic signed [SB:0] lin_d_s7;
	logic signed [SB-1:0] z1_s7, z1_s8, z1_s9;
	logic [1:0] mode_s7, mode_s8, mode_s9;
	logic vv_s7, vv_s8, vv_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [SB+3:0] a0, a1, a2, a3;
			a0 = (SB+4)'($signed(z6[0][SB-1:0]));
			a1 = (SB+4)'($signed(z6[1][SB-1:0]));
			a2 = (SB+4)'($signed(z6[2][SB-1:0]));
			a3 = (SB+4)'($signed(z6[3][SB-1:0]));
			ca_s7 <= (SB+4)'(3 * (a1 - a2) + a3 - a0);
			cb_s7 <= (SB+4)'(2 * a0 - 5 * a1 + 4 * a2 - a3);
			cc_s7 <= a2 - a0;
			cd_s7 <= (SB+4)'(2 * a1);
			lin_d_s7 <= (SB+1)'(a2 - a1);
			z1_s7 <= z6[1][SB-1:0];
			t_s7 <= t_s6;
			if (!z6[1][SB] || !z6[2][SB]) begin
				mode_s7 <= ModeNearest;
				vv_s7 <= z6[1][SB];
			end else if (!z6[0][SB] || !z6[3][SB]) begin
				mode_s7 <= ModeLinear;
				vv_s7 <= 1'b1;
			end else begin
				mode_s7 <= ModeCubic;
				vv_s7 <= 1'b1;
			end
		end
	end

	// s8..s9 horner; s10 final
	logic signed [HB-1:0] h_s8, h_s9;
	logic signed [SB+3:0] cc_s8, cd_s8, cd_s9;
	logic signed [SB:0] lin_s8;
	logic signed [SB+1:0] lin_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			h_s8 <= HB'((48'(ca_s7) * $signed({1'b0, t_s7})) >>> FracBits) + HB'(cb_s7);
			lin_s8 <= (SB+1)'((48'(lin_d_s7) * $signed({1'b0, t_s7})) >>> FracBits);
			cc_s8 <= cc_s7; cd_s8 <= cd_s7; z1_s8 <= z1_s7; t_s8 <= t_s7;
			mode_s8 <= mode_s7; vv_s8 <= vv_s7;
			h_s9 <= HB'((56'(h_s8) * $signed({1'b0, t_s8})) >>> FracBits) + HB'(cc_s8);
			lin_s9 <= (SB+2)'(z1_s8) + (SB+2)'(lin_s8);
			cd_s9 <= cd_s8; z1_s9 <= z1_s8; t_s9 <= t_s8;
			mode_s9 <= mode_s8; vv_s9 <= vv_s8;
		end
	end

	logic signed [HB:0] hf;
	logic signed [HB:0] res_w;
	rsp_t res;
	always_comb begin
		hf = (HB+1)'((56'(h_s9) * $signed({1'b0, t_s9})) >>> FracBits) + (HB+1)'(cd_s9);
		case (mode_s9)
			ModeCubic: res_w = (hf + (HB+1)'(1)) >>> 1;
			ModeLinear: res_w = (HB+1)'(lin_s9);
			default: res_w = vv_s9 ? (HB+1)'(z1_s9) : '0;
		endcase
		res.mode = mode_s9;
		res.value_valid = vv_s9;
		if (res_w > (HB+1)'((1 << (SB-1)) - 1)) res.value = {1'b0, {(SB-1){1'b1}}};
		else if (res_w < -(HB+1)'(1 << (SB-1))) res.value = {1'b1, {(SB-1){1'b0}}};
		else res.value = res_w[SB-1:0];
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				if (skid_full_q) begin
					out_valid_q <= 1'b1;
					skid_full_q <= 1'b0;
				end else out_valid_q <= adv && v_q[Stages-2];
			end else if (!out_valid_q) out_valid_q <= adv && v_q[Stages-2];
			else if (adv && v_q[Stages-2]) skid_full_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (out_valid_q && rsp.ready) begin
			if (skid_full_q) out_q <= skid_q;
			else out_q <= res;
		end else if (!out_valid_q) out_q <= res;
		else if (adv) skid_q <= res;
	end
	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;

endmodule
